// ----- rtl/stereo_peak_rms_ppm_meter_macros.svh -----
// assertion macros for the meter
`ifndef STEREO_PEAK_RMS_PPM_METER_MACROS_SVH
`define STEREO_PEAK_RMS_PPM_METER_MACROS_SVH
`ifndef SYNTHESIS
`define SPM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPM_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/spm_pkg.sv -----
package spm_pkg;
  localparam int OUT_W = 23;
  localparam int SUM_W = 59;
  localparam int REL_W = 24;
  localparam int ADDR_W = 4;
  localparam int DEF_MAX_BLOCK = 4096;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam logic [ADDR_W-1:0] REG_RELEASE = 4'h0;
  localparam logic [ADDR_W-1:0] REG_MODE = 4'h4;
  localparam logic [ADDR_W-1:0] REG_FLOOR = 4'h8;
  localparam logic [REL_W-1:0] RELEASE_RESET = 24'd16776410;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input request
    logic decay_l;    // multiply left needle
    logic decay_r;    // multiply right needle
    logic accum;      // fold sample into peaks and sum
    logic fin_start;  // latch block results, start division
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
    logic finish;     // attack needles, form result
  } spm_cmd_t;
endpackage

// ----- rtl/spm_ctrl.sv -----
module spm_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic in_last,
  input  logic out_free,
  output logic busy,
  output spm_pkg::spm_cmd_t cmd
);
  import spm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC_L, S_DEC_R, S_ACC, S_FIN, S_DIV, S_SQI, S_SQ, S_DONE
  } state_t;

  state_t state;
  logic [5:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_fire) state <= S_DEC_L;
        S_DEC_L: state <= S_DEC_R;
        S_DEC_R: state <= S_ACC;
        S_ACC: state <= in_last ? S_FIN : S_IDLE;
        S_FIN: begin
          state <= S_DIV;
          cnt <= '0;
        end
        S_DIV: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd58) state <= S_SQI;
        end
        S_SQI: begin
          state <= S_SQ;
          cnt <= '0;
        end
        S_SQ: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd29) state <= S_DONE;
        end
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_fire;
    cmd.decay_l = (state == S_DEC_L);
    cmd.decay_r = (state == S_DEC_R);
    cmd.accum = (state == S_ACC);
    cmd.fin_start = (state == S_FIN);
    cmd.div_step = (state == S_DIV);
    cmd.sqrt_start = (state == S_SQI);
    cmd.sqrt_step = (state == S_SQ);
    cmd.finish = (state == S_DONE) && out_free;
  end
endmodule

// ----- rtl/spm_datapath.sv -----
module spm_datapath #(
  parameter int MAX_BLOCK = spm_pkg::DEF_MAX_BLOCK,
  parameter int SAMPLE_BITS = spm_pkg::DEF_SAMPLE_BITS
) (
  input  logic clk,
  input  logic rst,
  input  spm_pkg::spm_cmd_t cmd,
  input  logic [SAMPLE_BITS-1:0] in_left,
  input  logic [SAMPLE_BITS-1:0] in_right,
  input  logic [spm_pkg::REL_W-1:0] release_per_sample,
  input  logic stereo_mode,
  input  logic [spm_pkg::OUT_W-1:0] decay_floor,
  output logic [spm_pkg::OUT_W-1:0] peak_left,
  output logic [spm_pkg::OUT_W-1:0] peak_right,
  output logic [spm_pkg::OUT_W-1:0] rms_level,
  output logic [spm_pkg::OUT_W-1:0] ppm_left,
  output logic [spm_pkg::OUT_W-1:0] ppm_right
);
  import spm_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int DIVS_W = CNT_W + 1;
  localparam int PK_W = SAMPLE_BITS - 1;
  localparam int SQ_W = 2 * SAMPLE_BITS;
  localparam logic [PK_W-1:0] PEAK_MAX = {PK_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK);

  logic [SAMPLE_BITS-1:0] smp_l, smp_r;
  logic [PK_W-1:0] run_l, run_r;
  logic [SUM_W-1:0] square_sum;
  logic [CNT_W-1:0] count;
  logic [OUT_W-1:0] needle_l, needle_r;

  // decay: one multiplier shared between needles
  logic [OUT_W-1:0] dec_in, dec_q;
  logic [OUT_W+REL_W-1:0] prod;
  assign dec_in = cmd.decay_l ? needle_l : needle_r;
  assign prod = dec_in * release_per_sample;
  assign dec_q = (prod[OUT_W+REL_W-1:REL_W] < decay_floor) ? '0 :
                 prod[OUT_W+REL_W-1:REL_W];

  function automatic logic [SAMPLE_BITS-1:0] abs_raw(input logic [SAMPLE_BITS-1:0] v);
    abs_raw = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  logic [SAMPLE_BITS-1:0] al, ar;
  logic [PK_W-1:0] ml, mr;
  logic [SQ_W-1:0] sql, sqr;
  logic [SUM_W+1:0] sum_add;
  assign al = abs_raw(smp_l);
  assign ar = abs_raw(smp_r);
  assign ml = al[SAMPLE_BITS-1] ? PEAK_MAX : al[PK_W-1:0];
  assign mr = ar[SAMPLE_BITS-1] ? PEAK_MAX : ar[PK_W-1:0];
  assign sql = al * al;
  assign sqr = stereo_mode ? ar * ar : '0;
  assign sum_add = (SUM_W+2)'(square_sum) + (SUM_W+2)'(sql) + (SUM_W+2)'(sqr);

  // restoring divide then digit-by-digit root
  logic [SUM_W-1:0] quo;
  logic [DIVS_W:0] rem;
  logic [DIVS_W-1:0] divisor;
  logic [DIVS_W:0] rem_sh;
  logic [SUM_W-1:0] sq_x;
  logic [SUM_W+1:0] sq_bit, sq_root, sq_trial;
  logic [SUM_W-1:0] blk_sum;
  logic [PK_W-1:0] pl_hold, pr_hold;

  assign rem_sh = {rem[DIVS_W-1:0], quo[SUM_W-1]};
  assign sq_trial = sq_root + sq_bit;

  logic [SUM_W+1:0] root_fin;
  assign root_fin = sq_root;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_l <= in_left;
      smp_r <= in_right;
    end
    if (rst) begin
      run_l <= '0;
      run_r <= '0;
      square_sum <= '0;
      count <= '0;
      needle_l <= '0;
      needle_r <= '0;
    end else begin
      if (cmd.decay_l) needle_l <= dec_q;
      if (cmd.decay_r) needle_r <= dec_q;
      if (cmd.accum) begin
        if (ml > run_l) run_l <= ml;
        if (stereo_mode && mr > run_r) run_r <= mr;
        square_sum <= (sum_add[SUM_W+1:SUM_W] != 2'b00) ? {SUM_W{1'b1}} :
                      sum_add[SUM_W-1:0];
        if (count < CNT_MAX) count <= count + 1'b1;
      end
      if (cmd.fin_start) begin
        run_l <= '0;
        run_r <= '0;
        square_sum <= '0;
        count <= '0;
      end
      if (cmd.finish) begin
        if (OUT_W'(pl_hold) > needle_l) needle_l <= OUT_W'(pl_hold);
        if (OUT_W'(pr_hold) > needle_r) needle_r <= OUT_W'(pr_hold);
      end
    end
    if (cmd.fin_start) begin
      pl_hold <= run_l;
      pr_hold <= stereo_mode ? run_r : run_l;
      blk_sum <= square_sum;
      quo <= square_sum;
      rem <= '0;
      divisor <= stereo_mode ? {count, 1'b0} : {1'b0, count};
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem <= rem_sh - {1'b0, divisor};
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.sqrt_start) begin
      sq_x <= quo;
      sq_root <= '0;
      sq_bit <= (SUM_W+2)'(1) << (SUM_W - 1);
    end
    if (cmd.sqrt_step) begin
      if ((SUM_W+2)'(sq_x) >= sq_trial) begin
        sq_x <= SUM_W'((SUM_W+2)'(sq_x) - sq_trial);
        sq_root <= (sq_root >> 1) + sq_bit;
      end else begin
        sq_root <= sq_root >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  assign peak_left = OUT_W'(pl_hold);
  assign peak_right = OUT_W'(pr_hold);
  assign rms_level = (root_fin > (SUM_W+2)'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} :
                     root_fin[OUT_W-1:0];
  assign ppm_left = (OUT_W'(pl_hold) > needle_l) ? OUT_W'(pl_hold) : needle_l;
  assign ppm_right = (OUT_W'(pr_hold) > needle_r) ? OUT_W'(pr_hold) : needle_r;

  logic unused;
  assign unused = ^{blk_sum, rem[DIVS_W]};
endmodule

// ----- rtl/stereo_peak_rms_ppm_meter.sv -----
// ordinary sample: captured, then the needles decay left then right, then it is accumulated;
//   a block-end sample then runs a serial divide and square root and waits for a free output
// no new sample is taken until the last one is through, set by the shared decay multiplier,
//   the accumulate step, and the serial divider and root at block ends
// reset: synchronous active-high rst clears needles, peaks, sum, count and registers
//   to their defaults; no clearing pass
module stereo_peak_rms_ppm_meter #(
  parameter int MAX_BLOCK = spm_pkg::DEF_MAX_BLOCK,
  parameter int SAMPLE_BITS = spm_pkg::DEF_SAMPLE_BITS
) (
  input  logic clk,
  input  logic rst,
  // s tdata: sample_left, sample_right (low to high), zero-padded to bytes
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  input  logic s_tlast,
  input  logic s_tvalid,
  output logic s_tready,
  // m tdata: peak_left, peak_right, rms_level, ppm_left, ppm_right (low to high)
  output logic [119:0] m_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [spm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import spm_pkg::*;
  `include "stereo_peak_rms_ppm_meter_macros.svh"

  // configuration registers
  logic [REL_W-1:0] release_per_sample;
  logic stereo_mode;
  logic [OUT_W-1:0] decay_floor;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_per_sample <= RELEASE_RESET;
      stereo_mode <= 1'b1;
      decay_floor <= OUT_W'(1);
    end else if (cfg_wr) begin
      case (paddr)
        REG_RELEASE: release_per_sample <= pwdata[REL_W-1:0];
        REG_MODE: stereo_mode <= pwdata[0];
        REG_FLOOR: decay_floor <= pwdata[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_RELEASE: prdata = 32'(release_per_sample);
      REG_MODE: prdata = 32'(stereo_mode);
      REG_FLOOR: prdata = 32'(decay_floor);
      default: prdata = '0;
    endcase
  end

  // handshake and block-end flag
  logic busy, in_fire, last_q;
  spm_cmd_t cmd;
  assign s_tready = !busy;
  assign in_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (in_fire) last_q <= s_tlast;
  end

  // output register: the result leaves while the next samples are taken
  logic [OUT_W-1:0] pk_l, pk_r, rms, pp_l, pp_r;
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cmd.finish) m_tvalid <= 1'b1;
    end
    if (cmd.finish) m_tdata <= {5'b0, pp_r, pp_l, rms, pk_r, pk_l};
  end

  spm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_last(last_q),
    .out_free(out_free), .busy(busy), .cmd(cmd)
  );

  spm_datapath #(.MAX_BLOCK(MAX_BLOCK), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .in_left(s_tdata[SAMPLE_BITS-1:0]),
    .in_right(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .release_per_sample(release_per_sample), .stereo_mode(stereo_mode),
    .decay_floor(decay_floor),
    .peak_left(pk_l), .peak_right(pk_r), .rms_level(rms),
    .ppm_left(pp_l), .ppm_right(pp_r)
  );

  // a result is only issued from the block-end path
  `SPM_ASSERT_IMPL(a_finish_last, clk, rst, cmd.finish, last_q, "result without block end")
  // a new result never overwrites one still waiting
  `SPM_ASSERT_IMPL(a_no_overrun, clk, rst, cmd.finish, out_free, "result overrun")
  // no request accepted while work is in flight
  `SPM_ASSERT_NEXT(a_busy_after, clk, rst, in_fire, busy, "controller idle after request")
endmodule

// ----- tb/sv/stereo_peak_rms_ppm_meter_checker.sv -----
`timescale 1ns / 100ps
module stereo_peak_rms_ppm_meter_checker (
  input  logic clk,
  input  logic rst,
  input  logic [47:0] s_tdata,
  input  logic s_tlast,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [119:0] m_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [spm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic pready,
  output int fail_count,
  output int pending_levels
);
  import spm_pkg::*;

  localparam logic [58:0] SUM_SAT = {59{1'b1}};
  localparam logic [22:0] LEVEL_MAX = {23{1'b1}};
  localparam int BLOCK_LIMIT = 4096;

  typedef struct packed {
    logic [22:0] ppm_r;
    logic [22:0] ppm_l;
    logic [22:0] rms;
    logic [22:0] peak_r;
    logic [22:0] peak_l;
  } level_set_t;

  level_set_t level_queue[$];

  logic [23:0] release_q;
  logic stereo_q;
  logic [22:0] floor_q;
  logic [22:0] blk_peak_l, blk_peak_r, needle_l, needle_r;
  logic [58:0] sq_sum;
  logic [12:0] blk_count;

  assign pending_levels = level_queue.size();

  function automatic logic [22:0] decayed(input logic [22:0] n);
    logic [46:0] p;
    p = n * release_q;
    return (p[46:24] < floor_q) ? 23'd0 : p[46:24];
  endfunction

  function automatic logic [23:0] abs_of(input logic signed [23:0] v);
    return v[23] ? -v : v;
  endfunction

  function automatic logic [58:0] int_sqrt(input logic [58:0] x);
    logic [63:0] rem, root, bit_v;
    rem = x;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > rem) bit_v >>= 2;
    while (bit_v != 0) begin
      if (rem >= root + bit_v) begin
        rem -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root[58:0];
  endfunction

  task automatic accumulate(input logic signed [23:0] v, inout logic [22:0] pk);
    logic [23:0] a;
    logic [58:0] sq;
    a = abs_of(v);
    sq = a * a;
    if ((a > 24'(LEVEL_MAX) ? LEVEL_MAX : a[22:0]) > pk)
      pk = (a > 24'(LEVEL_MAX)) ? LEVEL_MAX : a[22:0];
    if (sq_sum > SUM_SAT - sq) sq_sum = SUM_SAT;
    else sq_sum = sq_sum + sq;
  endtask

  task automatic meter_sample(input logic [47:0] d, input logic last);
    level_set_t r;
    logic [58:0] q;
    logic [58:0] rt;
    logic [13:0] div;
    needle_l = decayed(needle_l);
    needle_r = decayed(needle_r);
    accumulate(d[23:0], blk_peak_l);
    if (stereo_q) accumulate(d[47:24], blk_peak_r);
    if (blk_count < BLOCK_LIMIT) blk_count++;
    if (last) begin
      div = stereo_q ? {blk_count, 1'b0} : {1'b0, blk_count};
      q = sq_sum / div;
      rt = int_sqrt(q);
      r.peak_l = blk_peak_l;
      r.peak_r = stereo_q ? blk_peak_r : blk_peak_l;
      r.rms = (rt > 59'(LEVEL_MAX)) ? LEVEL_MAX : rt[22:0];
      if (r.peak_l > needle_l) needle_l = r.peak_l;
      if (r.peak_r > needle_r) needle_r = r.peak_r;
      r.ppm_l = needle_l;
      r.ppm_r = needle_r;
      level_queue.push_back(r);
      blk_peak_l = 0;
      blk_peak_r = 0;
      sq_sum = 0;
      blk_count = 0;
    end
  endtask

  always @(posedge clk) begin
    level_set_t want, got;
    if (rst) begin
      release_q = RELEASE_RESET;
      stereo_q = 1'b1;
      floor_q = 23'd1;
      blk_peak_l = 0;
      blk_peak_r = 0;
      needle_l = 0;
      needle_r = 0;
      sq_sum = 0;
      blk_count = 0;
      fail_count = 0;
      level_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_RELEASE: release_q = pwdata[23:0];
          REG_MODE:    stereo_q = pwdata[0];
          REG_FLOOR:   floor_q = pwdata[22:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) meter_sample(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got = m_tdata[114:0];
        if (level_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = level_queue.pop_front();
          if (want != got) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch pkL %0d/%0d pkR %0d/%0d rms %0d/%0d ppmL %0d/%0d ppmR %0d/%0d",
                       want.peak_l, got.peak_l, want.peak_r, got.peak_r, want.rms, got.rms,
                       want.ppm_l, got.ppm_l, want.ppm_r, got.ppm_r);
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/stereo_peak_rms_ppm_meter_tb.sv -----
`timescale 1ns / 100ps
module stereo_peak_rms_ppm_meter_tb;
  import spm_pkg::*;

  logic clk, rst;
  logic [47:0] s_tdata;   // sample_left [23:0], sample_right [47:24]
  logic s_tlast, s_tvalid, s_tready;
  logic [119:0] m_tdata;  // peak_left, peak_right, rms_level, ppm_left, ppm_right
  logic m_tvalid, m_tready;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  int fail_count, pending_levels;

  // receiver behaviour: busy_mode 0 random idling, 1 never idle, 2 long hold-off
  int busy_mode;
  int hold_cycles;

  stereo_peak_rms_ppm_meter dut (.*);

  stereo_peak_rms_ppm_meter_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // overall limit: ~2000 requests, long blocks, stalls, all well inside this
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver side
  initial begin
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (busy_mode == 2) begin
        m_tready <= 0;
        if (hold_cycles > 0) hold_cycles--;
        else busy_mode = 0;
      end else if (busy_mode == 1) begin
        m_tready <= 1;
      end else begin
        m_tready <= ($urandom_range(99) >= 21);
      end
    end
  end

  task automatic reg_write(input logic [ADDR_W-1:0] a, input logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // one sample request, random gaps unless quiet
  task automatic send_sample(input logic [23:0] l, input logic [23:0] r, input logic last,
                             input bit quiet);
    if (!quiet)
      while ($urandom_range(99) < 21) begin
        @(posedge clk);
        s_tvalid <= 0;
      end
    @(posedge clk);
    s_tvalid <= 1;
    s_tdata <= {r, l};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    // accepted at this edge, so valid drops straight after it
    s_tvalid <= 0;
  endtask

  // first let the checker see the last request, then wait until all levels are out
  task automatic wait_drained(input int extra);
    @(posedge clk);
    while (pending_levels != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample(input int kind);
    case (kind)
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom_range(255)) - 24'd128;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_block(input int len, input bit quiet);
    int k;
    int kind;
    kind = $urandom_range(9);
    for (k = 0; k < len; k++)
      send_sample(rand_sample(kind < 1 ? $urandom_range(3) : 3),
                  rand_sample(kind < 1 ? $urandom_range(3) : 3), k == len - 1, quiet);
  endtask

  initial begin
    int sent, len, phase;
    busy_mode = 0;
    hold_cycles = 0;
    rst = 1;
    s_tvalid = 0; s_tdata = 0; s_tlast = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: extremes, single-sample blocks, mono copy
    send_sample(24'h800000, 24'h7FFFFF, 1, 0);
    send_sample(24'h000000, 24'h000000, 1, 0);
    send_sample(24'h7FFFFF, 24'h800000, 0, 0);
    send_sample(24'h800000, 24'h800000, 0, 0);
    send_sample(24'hFFFFFF, 24'h000001, 1, 0);
    send_sample(24'h123456, 24'hABCDEF, 0, 0);
    send_sample(24'hFEDCBA, 24'h654321, 1, 0);
    wait_drained(120);
    reg_write(REG_MODE, 32'd0);
    reg_write(REG_RELEASE, 32'hFFFFFF);
    reg_write(REG_FLOOR, 32'h7FFFFF);
    send_sample(24'h800000, 24'h7FFFFF, 1, 0);
    send_sample(24'h400000, 24'h800000, 0, 0);
    send_sample(24'h000000, 24'h7FFFFF, 1, 0);
    wait_drained(120);
    reg_write(REG_RELEASE, 32'd0);
    reg_write(REG_FLOOR, 32'd0);
    send_sample(24'h7FFFFF, 24'h0, 1, 0);
    send_sample(24'h000010, 24'h0, 1, 0);
    wait_drained(120);
    // mode change inside a block, once the first sample is fully processed
    reg_write(REG_MODE, 32'd1);
    send_sample(24'h7FFFFF, 24'h7FFFFF, 0, 0);
    wait_drained(8);
    reg_write(REG_MODE, 32'd0);
    send_sample(24'h100000, 24'h7FFFFF, 1, 0);
    wait_drained(120);

    // long block of full-scale samples, back to back
    reg_write(REG_MODE, 32'd1);
    reg_write(REG_RELEASE, 32'd16776410);
    reg_write(REG_FLOOR, 32'd1);
    for (int k = 0; k < 600; k++)
      send_sample(24'h800000, 24'h800000, k == 599, 1);
    wait_drained(120);

    // random phases through several settings
    sent = 0;
    phase = 0;
    while (sent < 1330) begin
      if (phase % 3 == 2) busy_mode = 1;
      if (phase == 4) begin
        // hold off the receiver while requests keep coming
        hold_cycles = 3000;
        busy_mode = 2;
      end
      for (int b = 0; b < 12 && sent < 1330; b++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
        random_block(len, phase % 3 == 2);
        sent += len;
      end
      // pause until all levels are back, then retune
      wait_drained(120);
      if (busy_mode == 1) busy_mode = 0;
      case ($urandom_range(3))
        0: reg_write(REG_RELEASE, 32'($urandom_range(16777215)));
        1: reg_write(REG_RELEASE, 32'($urandom_range(16777215, 16700000)));
        2: reg_write(REG_RELEASE, 32'hFFFFFF);
        default: reg_write(REG_RELEASE, 32'd0);
      endcase
      reg_write(REG_MODE, 32'($urandom_range(1)));
      reg_write(REG_FLOOR, ($urandom_range(3) == 0) ? 32'($urandom_range(8388607))
                                                    : 32'($urandom_range(4096)));
      phase++;
    end

    wait_drained(200);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/spm_pkg.sv
rtl/spm_ctrl.sv
rtl/spm_datapath.sv
rtl/stereo_peak_rms_ppm_meter.sv
tb/sv/stereo_peak_rms_ppm_meter_checker.sv
tb/sv/stereo_peak_rms_ppm_meter_tb.sv
